@@ rtl/core/indexed_list_insert_delete_macros.svh @@
// Assertion macros shared by the indexed list block.
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ila_pkg.sv @@
// Types and constants of the indexed list block.
package ila_pkg;

   localparam int WORD_W  = 32;
   localparam int KIND_W  = 3;
   localparam int REQ_POS_W = 7;
   localparam int STAT_W  = 2;
   localparam int ECNT_W  = 7;
   // Width of an internal position; covers the largest supported capacity.
   localparam int POS_W   = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ = 3'd0,
      KIND_HEAD = 3'd1,
      KIND_TAIL = 3'd2,
      KIND_AT   = 3'd3,
      KIND_DEL  = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam logic signed [WORD_W-1:0] MISS_VALUE = -32'sd1;

   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] word;
   } cell_ctrl_type;

endpackage

@@ rtl/core/ila_req_if.sv @@
// Request channel of the indexed list block.
interface ila_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ila_pkg::KIND_W-1:0]           kind;
   logic [ila_pkg::REQ_POS_W-1:0]        position;
   logic signed [ila_pkg::WORD_W-1:0]    word;

   modport source (output valid, output kind, output position, output word, input ready);
   modport sink (input valid, input kind, input position, input word, output ready);
endinterface

@@ rtl/core/ila_rsp_if.sv @@
// Response channel of the indexed list block.
interface ila_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ila_pkg::WORD_W-1:0]    read_value;
   logic [ila_pkg::STAT_W-1:0]           status;
   logic [ila_pkg::ECNT_W-1:0]           entry_count;

   modport source (output valid, output read_value, output status, output entry_count,
                   input ready);
   modport sink (input valid, input read_value, input status, input entry_count,
                 output ready);
endinterface

@@ rtl/core/ila_cell.sv @@
// One storage cell of the list; shifts toward or away from the head on command.
module ila_cell #(
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  ila_pkg::cell_ctrl_type               ctrl,
   input  logic signed [ila_pkg::WORD_W-1:0]    left_data,
   input  logic signed [ila_pkg::WORD_W-1:0]    right_data,
   output logic signed [ila_pkg::WORD_W-1:0]    data_out,
   output logic signed [ila_pkg::WORD_W-1:0]    read_out
);

   localparam logic [ila_pkg::POS_W-1:0] MY_IDX = ila_pkg::POS_W'(INDEX);

   logic signed [ila_pkg::WORD_W-1:0] entry_ff;
   logic signed [ila_pkg::WORD_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (MY_IDX > ctrl.pos) begin
            entry_in = left_data;
         end else if (MY_IDX == ctrl.pos) begin
            entry_in = ctrl.word;
         end
      end else if (ctrl.del) begin
         if (MY_IDX >= ctrl.pos) begin
            entry_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data_out = entry_ff;
   assign read_out = (MY_IDX == ctrl.pos) ? entry_ff : '0;

endmodule

@@ rtl/core/indexed_list_insert_delete.sv @@
// Top level of the indexed list block: request decode, cell row and response register.
//
// The block holds an ordered list of up to CAPACITY signed 32-bit words in a row
// of cells, one word per cell. Each request item on the req_ channel reads,
// inserts at the head, the tail or a position, or deletes at a position; every
// request gives exactly one response item on the rsp_ channel with the read value,
// a status (done, position out of range, list full) and the entry count after it.
// The whole row shifts in the cycle the item is accepted, and the response is
// registered, so it appears in the next cycle. Throughput is one item per cycle
// while the receiver is ready; the single response register sets it.
// The request side stays ready while the response register is empty or is being
// drained in the same cycle, so a stalled receiver holds the response and stops
// new requests without losing or repeating anything.
// Reset empties the list at once by clearing the entry count; cell contents are
// not cleared, since positions at or beyond the count are never read.
// A read outside the list answers -1; refused inserts and deletes change nothing.
// The entry count is reported in its low seven bits.
`include "indexed_list_insert_delete_macros.svh"

module indexed_list_insert_delete #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   ila_req_if.sink    req_chan,
   ila_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [ila_pkg::POS_W-1:0] CAP_POS = ila_pkg::POS_W'(CAPACITY);

   logic [CW-1:0]                     count_ff;
   logic [CW-1:0]                     count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [ila_pkg::WORD_W-1:0] rsp_value_ff;
   logic signed [ila_pkg::WORD_W-1:0] rsp_value_in;
   ila_pkg::status_type               rsp_status_ff;
   ila_pkg::status_type               rsp_status_in;
   logic [ila_pkg::ECNT_W-1:0]        rsp_count_ff;
   logic [ila_pkg::ECNT_W-1:0]        rsp_count_in;

   logic                              accept;
   logic [ila_pkg::POS_W-1:0]         count_pos;
   logic [ila_pkg::POS_W-1:0]         req_pos;
   logic                              do_ins;
   logic                              do_del;
   ila_pkg::status_type               status;
   logic signed [ila_pkg::WORD_W-1:0] value;
   logic signed [ila_pkg::WORD_W-1:0] read_bus;
   ila_pkg::cell_ctrl_type            ctrl;

   logic signed [ila_pkg::WORD_W-1:0] cell_data [CAPACITY];
   logic signed [ila_pkg::WORD_W-1:0] cell_read [CAPACITY];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign count_pos      = ila_pkg::POS_W'(count_ff);
   assign req_pos        = ila_pkg::POS_W'(req_chan.position);

   always_comb begin
      do_ins   = 1'b0;
      do_del   = 1'b0;
      status   = ila_pkg::ST_DONE;
      value    = '0;
      ctrl.pos = req_pos;
      unique case (ila_pkg::kind_type'(req_chan.kind)) inside
         ila_pkg::KIND_READ: begin
            if (req_pos < count_pos) begin
               value = read_bus;
            end else begin
               value  = ila_pkg::MISS_VALUE;
               status = ila_pkg::ST_RANGE;
            end
         end
         ila_pkg::KIND_HEAD, ila_pkg::KIND_TAIL, ila_pkg::KIND_AT: begin
            if (ila_pkg::kind_type'(req_chan.kind) == ila_pkg::KIND_HEAD) begin
               ctrl.pos = '0;
            end else if (ila_pkg::kind_type'(req_chan.kind) == ila_pkg::KIND_TAIL) begin
               ctrl.pos = count_pos;
            end
            if (ctrl.pos > count_pos) begin
               status = ila_pkg::ST_RANGE;
            end else if (count_pos == CAP_POS) begin
               status = ila_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ila_pkg::KIND_DEL: begin
            if (req_pos >= count_pos) begin
               status = ila_pkg::ST_RANGE;
            end else begin
               do_del = 1'b1;
            end
         end
         default: begin
            status = ila_pkg::ST_DONE;
         end
      endcase
      ctrl.ins  = do_ins && accept;
      ctrl.del  = do_del && accept;
      ctrl.word = req_chan.word;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [ila_pkg::WORD_W-1:0] left_d;
         logic signed [ila_pkg::WORD_W-1:0] right_d;
         if (gi == 0) begin : g_first
            assign left_d = req_chan.word;
         end else begin : g_left
            assign left_d = cell_data[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[gi];
         end else begin : g_right
            assign right_d = cell_data[gi+1];
         end
         ila_cell #(
            .INDEX (gi)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[gi]),
            .read_out   (cell_read[gi])
         );
      end
   endgenerate

   always_comb begin
      read_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_bus = read_bus | cell_read[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.del) begin
         count_in = count_ff - 1'b1;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = value;
         rsp_status_in = status;
         rsp_count_in  = ila_pkg::ECNT_W'(ila_pkg::POS_W'(count_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   `ILA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_pos <= CAP_POS, "count exceeds capacity")
   `ILA_ASSERT_NEXT(a_ins_count, clock, reset, ctrl.ins, count_ff == CW'($past(count_ff) + 1'b1), "insert did not grow the list")
   `ILA_ASSERT_NEXT(a_del_count, clock, reset, ctrl.del, count_ff == CW'($past(count_ff) - 1'b1), "delete did not shrink the list")
   `ILA_ASSERT_NEXT(a_rsp_after_req, clock, reset, accept, rsp_valid_ff && rsp_count_ff == ila_pkg::ECNT_W'(count_pos), "accepted item gave no response")

endmodule
